// ----- sv/spic_pkg.sv -----
`default_nettype none

package spic_pkg;

  localparam int unsigned NUM_LEVELS = 7;
  localparam int unsigned LvlW       = $clog2(NUM_LEVELS + 1);
  localparam int unsigned StatusW    = 25;
  localparam int unsigned TestW      = 18;
  localparam int unsigned ProgLsb    = 18;
  localparam int unsigned ActLsb     = 8;
  localparam int unsigned OnBit      = 7;

  typedef logic [NUM_LEVELS-1:0] lvl_mask_t;
  typedef logic [LvlW-1:0]       lvl_t;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_READ    = 3'd1,
    KIND_CONSO   = 3'd2,
    KIND_CONSZ   = 3'd3,
    KIND_IO_REQ  = 3'd4,
    KIND_DISMISS = 3'd5,
    KIND_GRANT   = 3'd6
  } kind_e;

  localparam int unsigned CMD_CLEAR     = 0;
  localparam int unsigned CMD_OFF       = 1;
  localparam int unsigned CMD_ON        = 2;
  localparam int unsigned CMD_LVL_ON    = 3;
  localparam int unsigned CMD_LVL_OFF   = 4;
  localparam int unsigned CMD_PROG_SET  = 5;
  localparam int unsigned CMD_PROG_CLR  = 6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  command;
    logic [6:0]  level_mask;
    logic [17:0] test_mask;
    logic [2:0]  io_level;
    logic        io_vectored;
    logic        apr_pending;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         pending_level;
    logic [StatusW-1:0] status_word;
    logic               skip;
    logic [2:0]         granted_level;
  } out_beat_t;

  typedef struct packed {
    logic      sys_on;
    lvl_mask_t enables;
    lvl_mask_t actives;
    lvl_mask_t io_req;
    lvl_mask_t prog_req;
    lvl_t      pending;
  } spic_state_t;

  function automatic lvl_mask_t level_bit(input lvl_t lvl);
    lvl_mask_t m;
    m = '0;
    if (lvl != '0 && 32'(lvl) <= NUM_LEVELS) begin
      m = lvl_mask_t'(1) << (NUM_LEVELS - 32'(lvl));
    end
    return m;
  endfunction

  // highest priority (lowest number) set level, 0 if none
  function automatic lvl_t top_level(input lvl_mask_t m);
    lvl_t lvl;
    lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (m[i]) begin
        lvl = LvlW'(NUM_LEVELS - i);
      end
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ----- sv/spic_core.sv -----
`default_nettype none

module spic_core (
  input  spic_pkg::spic_state_t state_i,
  input  spic_pkg::in_beat_t    beat_i,
  input  logic [2:0]            cond_lvl_i,
  output spic_pkg::spic_state_t state_o,
  output spic_pkg::out_beat_t   beat_o
);
  import spic_pkg::*;

  spic_state_t st;
  lvl_mask_t   lm;
  lvl_mask_t   apr_mask;
  lvl_t        req_lvl;
  lvl_t        act_lvl;
  logic [TestW-1:0] test_word;
  logic        skip;
  lvl_t        granted;

  always_comb begin
    st        = state_i;
    lm        = beat_i.level_mask[NUM_LEVELS-1:0];
    skip      = 1'b0;
    granted   = '0;
    test_word = TestW'({state_i.actives, state_i.sys_on, state_i.enables});

    case (beat_i.kind)
      KIND_WRITE: begin
        if (beat_i.command[CMD_CLEAR]) begin
          st.sys_on   = 1'b0;
          st.enables  = '0;
          st.actives  = '0;
          st.prog_req = '0;
        end
        if (beat_i.command[CMD_OFF])      st.sys_on   = 1'b0;
        if (beat_i.command[CMD_ON])       st.sys_on   = 1'b1;
        if (beat_i.command[CMD_LVL_ON])   st.enables  = st.enables | lm;
        if (beat_i.command[CMD_LVL_OFF])  st.enables  = st.enables & ~lm;
        if (beat_i.command[CMD_PROG_SET]) st.prog_req = st.prog_req | lm;
        if (beat_i.command[CMD_PROG_CLR]) st.prog_req = st.prog_req & ~lm;
      end
      KIND_CONSO: skip = (beat_i.test_mask & test_word) != '0;
      KIND_CONSZ: skip = (beat_i.test_mask & test_word) == '0;
      KIND_IO_REQ: st.io_req = state_i.io_req | level_bit(LvlW'(beat_i.io_level));
      KIND_DISMISS: st.actives = state_i.actives & ~level_bit(top_level(state_i.actives));
      KIND_GRANT: begin
        if (state_i.pending != '0) begin
          if (beat_i.io_vectored) begin
            st.io_req = state_i.io_req & ~level_bit(top_level(state_i.io_req));
          end
          st.actives = state_i.actives | level_bit(state_i.pending);
          granted    = state_i.pending;
        end
      end
      default: ;
    endcase

    apr_mask = beat_i.apr_pending ? level_bit(LvlW'(cond_lvl_i)) : '0;
    req_lvl  = top_level((apr_mask | st.io_req | st.prog_req) & st.enables);
    act_lvl  = top_level(st.actives);
    st.pending = '0;
    if (st.sys_on && (act_lvl == '0 || req_lvl < act_lvl)) begin
      st.pending = req_lvl;
    end
  end

  assign state_o = st;

  always_comb begin
    beat_o               = '0;
    beat_o.pending_level = 3'(st.pending);
    beat_o.status_word[ProgLsb +: NUM_LEVELS] = st.prog_req;
    beat_o.status_word[ActLsb +: NUM_LEVELS]  = st.actives;
    beat_o.status_word[OnBit]                 = st.sys_on;
    beat_o.status_word[NUM_LEVELS-1:0]        = st.enables;
    beat_o.skip          = skip;
    beat_o.granted_level = 3'(granted);
  end

endmodule

`default_nettype wire

// ----- sv/seven_level_priority_interrupt.sv -----
`default_nettype none

// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  in_beat_i   (spic_pkg::in_beat_t)
// out      output     out_valid_o/out_stall_i out_beat_o (spic_pkg::out_beat_t)
// cfg      input      cfg_we_i               cfg_wdata_i (condition level)
//
// One beat per cycle while in_stall_o is low: each accepted beat updates the state and loads the
// result register at the same edge; its result is offered the next cycle.
// in_stall_o is high only while a held result is stalled downstream.
// rst_ni clears all state, the condition level and the result valid.

module seven_level_priority_interrupt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spic_pkg::in_beat_t in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spic_pkg::out_beat_t out_beat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i
);
  import spic_pkg::*;

  spic_state_t state_q, state_d;
  out_beat_t   res_d, res_q;
  logic        out_valid_q;
  logic [2:0]  cond_lvl_q;
  logic        in_accept;

  spic_core u_core (
    .state_i    (state_q),
    .beat_i     (in_beat_i),
    .cond_lvl_i (cond_lvl_q),
    .state_o    (state_d),
    .beat_o     (res_d)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
      cond_lvl_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cond_lvl_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = res_q;

endmodule

`default_nettype wire

// ----- bench/tb_seven_level_priority_interrupt.sv -----
`default_nettype none

module tb_seven_level_priority_interrupt;
  timeunit 1ns;
  timeprecision 1ps;

  import spic_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int unsigned PHASE_BEATS = 90;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } directed_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_beat_o;
  logic      cfg_we_i;
  logic [2:0] cfg_wdata_i;

  bit        row_typed;
  out_beat_t row_want;
  bit        calm;
  int        mismatch_count;

  // predictor state
  logic      pr_on;
  lvl_mask_t pr_enables;
  lvl_mask_t pr_active;
  lvl_mask_t pr_io;
  lvl_mask_t pr_prog;
  lvl_t      pr_pending;
  lvl_t      pr_cond_lvl;

  out_beat_t expected_results[$];
  out_beat_t forecast;
  out_beat_t oldest;
  directed_row_t directed[$];

  seven_level_priority_interrupt DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("seven_level_priority_interrupt regression: fail");
    $finish;
  end

  function automatic lvl_mask_t mask_of_level(input lvl_t l);
    lvl_mask_t m;
    m = '0;
    if (l >= 1 && l <= NUM_LEVELS) m = lvl_mask_t'(1) << (NUM_LEVELS - l);
    return m;
  endfunction

  // level 1 sits in the top bit, so scan downward from there
  function automatic lvl_t highest_level(input lvl_mask_t m);
    lvl_t l;
    bit   hit;
    l = '0;
    hit = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (m[i] && !hit) begin
        l = lvl_t'(NUM_LEVELS - i);
        hit = 1'b1;
      end
    end
    return l;
  endfunction

  function automatic out_beat_t advance_controller(input in_beat_t b);
    out_beat_t r;
    lvl_mask_t reqs;
    lvl_t      req_top;
    lvl_t      act_top;
    logic [TestW-1:0] tword;
    r = '0;
    tword = {3'b000, pr_active, pr_on, pr_enables};
    case (b.kind)
      KIND_WRITE: begin
        if (b.command[CMD_CLEAR]) begin
          pr_on = 1'b0;
          pr_enables = '0;
          pr_active = '0;
          pr_prog = '0;
        end
        if (b.command[CMD_OFF]) pr_on = 1'b0;
        if (b.command[CMD_ON]) pr_on = 1'b1;
        if (b.command[CMD_LVL_ON]) pr_enables = pr_enables | b.level_mask;
        if (b.command[CMD_LVL_OFF]) pr_enables = pr_enables & ~b.level_mask;
        if (b.command[CMD_PROG_SET]) pr_prog = pr_prog | b.level_mask;
        if (b.command[CMD_PROG_CLR]) pr_prog = pr_prog & ~b.level_mask;
      end
      KIND_CONSO: r.skip = |(b.test_mask & tword);
      KIND_CONSZ: r.skip = ~|(b.test_mask & tword);
      KIND_IO_REQ: pr_io = pr_io | mask_of_level(b.io_level);
      KIND_DISMISS: pr_active = pr_active & ~mask_of_level(highest_level(pr_active));
      KIND_GRANT: begin
        if (pr_pending != '0) begin
          if (b.io_vectored) pr_io = pr_io & ~mask_of_level(highest_level(pr_io));
          pr_active = pr_active | mask_of_level(pr_pending);
          r.granted_level = pr_pending;
        end
      end
      default: ;
    endcase
    pr_pending = '0;
    if (pr_on) begin
      reqs = ((b.apr_pending ? mask_of_level(pr_cond_lvl) : '0) | pr_io | pr_prog) & pr_enables;
      req_top = highest_level(reqs);
      act_top = highest_level(pr_active);
      if (act_top == '0 || req_top < act_top) pr_pending = req_top;
    end
    r.pending_level = pr_pending;
    r.status_word = {pr_prog, 3'b000, pr_active, pr_on, pr_enables};
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) pr_cond_lvl = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat %h", out_beat_o);
        end else begin
          oldest = expected_results.pop_front();
          if (out_beat_o.pending_level !== oldest.pending_level ||
              out_beat_o.status_word !== oldest.status_word ||
              out_beat_o.skip !== oldest.skip ||
              out_beat_o.granted_level !== oldest.granted_level) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: pending %0d/%0d status %h/%h skip %0b/%0b granted %0d/%0d",
                       oldest.pending_level, out_beat_o.pending_level,
                       oldest.status_word, out_beat_o.status_word,
                       oldest.skip, out_beat_o.skip,
                       oldest.granted_level, out_beat_o.granted_level);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        forecast = advance_controller(in_beat_i);
        expected_results.push_back(row_typed ? row_want : forecast);
      end
    end
  end

  function automatic in_beat_t beat_of(input logic [2:0] k, input logic [6:0] cmd,
                                       input logic [6:0] lm, input logic [17:0] tm,
                                       input logic [2:0] iol, input logic vec,
                                       input logic aprp);
    in_beat_t b;
    b.kind = k;
    b.command = cmd;
    b.level_mask = lm;
    b.test_mask = tm;
    b.io_level = iol;
    b.io_vectored = vec;
    b.apr_pending = aprp;
    return b;
  endfunction

  function automatic out_beat_t outcome(input logic [2:0] p, input logic [StatusW-1:0] s,
                                        input logic k, input logic [2:0] g);
    out_beat_t r;
    r.pending_level = p;
    r.status_word = s;
    r.skip = k;
    r.granted_level = g;
    return r;
  endfunction

  task automatic offer(input in_beat_t b, input bit typed, input out_beat_t want);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_cond_lvl(input logic [2:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [2:0] k;
    logic [6:0] cmd;
    logic [2:0] apr_plan[5];
    int         pick;
    out_beat_t  none;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    row_typed = 1'b0;
    row_want = '0;
    calm = 1'b0;
    mismatch_count = 0;
    pr_on = 1'b0;
    pr_enables = '0;
    pr_active = '0;
    pr_io = '0;
    pr_prog = '0;
    pr_pending = '0;
    pr_cond_lvl = '0;
    none = '0;

    // after reset, empty grant, empty dismiss, unused kind, tests on a zero word
    directed.push_back('{beat_of(KIND_READ, 0, 0, 0, 0, 0, 0), 1, outcome(0, 0, 0, 0)});
    directed.push_back('{beat_of(KIND_GRANT, 0, 0, 0, 0, 1, 1), 1, outcome(0, 0, 0, 0)});
    directed.push_back('{beat_of(KIND_DISMISS, 0, 0, 0, 0, 0, 0), 1, outcome(0, 0, 0, 0)});
    directed.push_back('{beat_of(KIND_UNUSED, 7'h7F, 7'h7F, 18'h3FFFF, 7, 1, 1), 1,
                         outcome(0, 0, 0, 0)});
    directed.push_back('{beat_of(KIND_CONSO, 0, 0, 18'h3FFFF, 0, 0, 0), 1, outcome(0, 0, 0, 0)});
    directed.push_back('{beat_of(KIND_CONSZ, 0, 0, 18'h3FFFF, 0, 0, 0), 1, outcome(0, 0, 1, 0)});
    directed.push_back('{beat_of(KIND_IO_REQ, 0, 0, 0, 0, 0, 1), 1, outcome(0, 0, 0, 0)});
    directed.push_back('{beat_of(KIND_WRITE, 7'(1 << CMD_ON), 0, 0, 0, 0, 0), 1,
                         outcome(0, 25'h80, 0, 0)});
    directed.push_back('{beat_of(KIND_WRITE, 7'(1 << CMD_LVL_ON), 7'h7F, 0, 0, 0, 0), 1,
                         outcome(0, 25'hFF, 0, 0)});
    directed.push_back('{beat_of(KIND_IO_REQ, 0, 0, 0, 7, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_WRITE, 7'(1 << CMD_PROG_SET), 7'h7F, 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_GRANT, 0, 0, 0, 0, 1, 0), 0, none});
    directed.push_back('{beat_of(KIND_GRANT, 0, 0, 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_WRITE, 7'(1 << CMD_PROG_CLR), 7'h40, 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_CONSO, 0, 0, 18'h04000, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_CONSZ, 0, 0, 18'h00080, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_DISMISS, 0, 0, 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_GRANT, 0, 0, 0, 0, 0, 1), 0, none});
    directed.push_back('{beat_of(KIND_WRITE, 7'(1 << CMD_OFF), 0, 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_IO_REQ, 0, 0, 0, 1, 0, 1), 0, none});
    directed.push_back('{beat_of(KIND_WRITE, 7'((1 << CMD_ON) | (1 << CMD_LVL_OFF)), 7'h55,
                                 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_WRITE, 7'h7F, 7'h7F, 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_WRITE, 7'(1 << CMD_CLEAR), 0, 0, 0, 0, 0), 0, none});
    directed.push_back('{beat_of(KIND_READ, 0, 0, 0, 0, 0, 0), 0, none});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) offer(directed[i].beat, directed[i].typed, directed[i].want);

    apr_plan[0] = 3'd7;
    apr_plan[1] = 3'd1;
    apr_plan[2] = 3'd0;
    apr_plan[3] = 3'd4;
    apr_plan[4] = 3'($urandom_range(7));

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      set_cond_lvl(apr_plan[ph]);
      calm = (ph == 1);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(99);
        if (pick < 22) k = KIND_WRITE;
        else if (pick < 42) k = KIND_IO_REQ;
        else if (pick < 64) k = KIND_GRANT;
        else if (pick < 78) k = KIND_DISMISS;
        else if (pick < 86) k = KIND_CONSO;
        else if (pick < 94) k = KIND_CONSZ;
        else if (pick < 97) k = KIND_READ;
        else k = KIND_UNUSED;
        // keep the system on and populated most of the time
        cmd = 7'($urandom_range(127));
        if ($urandom_range(99) >= 8) cmd[CMD_CLEAR] = 1'b0;
        if ($urandom_range(99) >= 15) cmd[CMD_OFF] = 1'b0;
        offer(beat_of(k, cmd, 7'($urandom_range(127)), 18'($urandom_range(262143)),
                      3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1))),
              0, none);
      end
    end

    calm = 1'b0;
    drain();
    if (mismatch_count == 0) begin
      $display("seven_level_priority_interrupt regression: pass");
    end else begin
      $display("seven_level_priority_interrupt regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/spic_pkg.sv
sv/spic_core.sv
sv/seven_level_priority_interrupt.sv
bench/tb_seven_level_priority_interrupt.sv
